### rtl/xtea_cbc_encrypt_unit_assert.svh
// ----------------------------------------------------------------------------
// XTEA CBC encrypt unit assertion macros
// Concurrent assertion shorthands, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef XTEA_CBC_ENCRYPT_UNIT_ASSERT_SVH
`define XTEA_CBC_ENCRYPT_UNIT_ASSERT_SVH

// same-cycle implication
`define XCBC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define XCBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/xcbc_pkg.sv
// ----------------------------------------------------------------------------
// XTEA CBC package
// Types and constants shared by the XTEA CBC encrypt unit and its interfaces.
// ----------------------------------------------------------------------------
package xcbc_pkg;

   localparam int WORD_W  = 32;
   localparam int ROUND_W = 7;
   localparam int CSR_IDX_W = 3;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [ROUND_W-1:0]   round_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam word_type XTEA_DELTA = 32'h9E37_79B9;

   localparam word_type KEY0_RESET = 32'h8FCB_06DA;
   localparam word_type KEY1_RESET = 32'hAC19_3E62;
   localparam word_type KEY2_RESET = 32'h4150_0C5C;
   localparam word_type KEY3_RESET = 32'h64A7_B1DB;
   localparam round_type ROUNDS_RESET = 7'd32;

   localparam csr_idx_type REG_KEY0   = 3'd0;
   localparam csr_idx_type REG_KEY1   = 3'd1;
   localparam csr_idx_type REG_KEY2   = 3'd2;
   localparam csr_idx_type REG_KEY3   = 3'd3;
   localparam csr_idx_type REG_ROUNDS = 3'd4;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   function automatic word_type xtea_mix(input word_type x);
      return ((x << 4) ^ (x >> 5)) + x;
   endfunction

endpackage

### rtl/xcbc_if.sv
// ----------------------------------------------------------------------------
// XTEA CBC channel interfaces
// Valid/ready channels for plaintext words, ciphertext words and CSR writes.
// ----------------------------------------------------------------------------
interface xcbc_req_if;
   import xcbc_pkg::*;
   logic     valid;
   logic     ready;
   word_type plain_high;
   word_type plain_low;
   logic     start_message;
   modport source (output valid, plain_high, plain_low, start_message, input ready);
   modport sink   (input valid, plain_high, plain_low, start_message, output ready);
endinterface

interface xcbc_rsp_if;
   import xcbc_pkg::*;
   logic     valid;
   logic     ready;
   word_type cipher_high;
   word_type cipher_low;
   modport source (output valid, cipher_high, cipher_low, input ready);
   modport sink   (input valid, cipher_high, cipher_low, output ready);
endinterface

interface xcbc_csr_if;
   import xcbc_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   word_type    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/xtea_cbc_encrypt_unit.sv
// ----------------------------------------------------------------------------
// XTEA CBC encrypt unit
// Enciphers 64-bit words in CBC mode with a configurable key and round count.
// ----------------------------------------------------------------------------
// One plaintext word is taken at a time. It is XORed with the previous
// ciphertext (or zero when start_message is set) and run through a single
// shared XTEA half-round datapath, one half-round per clock. A word holds the
// input side until its result is posted: a load step, two half-rounds per
// round (32 rounds by default), then a post step that waits for the output
// register to be free. The result sits in an output register, so the next
// word can be taken while the previous ciphertext waits. CSR writes are always
// accepted; they should only be issued while the unit is idle.
`include "xtea_cbc_encrypt_unit_assert.svh"

module xtea_cbc_encrypt_unit (
   input  logic clock,
   input  logic reset,
   xcbc_req_if.sink   req,
   xcbc_rsp_if.source rsp,
   xcbc_csr_if.sink   csr
);
   import xcbc_pkg::*;

   state_type state_ff, state_in;
   word_type  hi_ff, hi_in;
   word_type  lo_ff, lo_in;
   word_type  total_ff, total_in;
   round_type cnt_ff, cnt_in;
   logic      phase_ff, phase_in;
   word_type  out_hi_ff, out_hi_in;
   word_type  out_lo_ff, out_lo_in;
   logic      rsp_valid_ff, rsp_valid_in;
   word_type  key_ff [4];
   round_type rounds_ff;

   logic      accept;
   logic      last;
   logic      step;
   logic      finish;
   logic [1:0] key_sel;
   word_type  src_word;
   word_type  dst_word;
   word_type  half_res;

   assign accept = req.valid & req.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req.ready = 1'b0;
      last      = 1'b0;
      step      = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
         end
         ST_RUN: begin
            last   = (cnt_ff == '0) && !phase_ff;
            step   = !last;
            finish = last && (!rsp_valid_ff || rsp.ready);
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   // shared half-round unit
   always_comb begin
      key_sel  = phase_ff ? total_ff[12:11] : total_ff[1:0];
      src_word = phase_ff ? hi_ff : lo_ff;
      dst_word = phase_ff ? lo_ff : hi_ff;
      half_res = dst_word + (xtea_mix(src_word) ^ (total_ff + key_ff[key_sel]));
   end

   always_comb begin
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      total_in = total_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      if (accept) begin
         hi_in    = req.start_message ? req.plain_high : req.plain_high ^ hi_ff;
         lo_in    = req.start_message ? req.plain_low  : req.plain_low  ^ lo_ff;
         total_in = '0;
         cnt_in   = rounds_ff;
         phase_in = 1'b0;
      end else if (step) begin
         phase_in = !phase_ff;
         if (phase_ff) begin
            lo_in  = half_res;
            cnt_in = cnt_ff - 1'b1;
         end else begin
            hi_in    = half_res;
            total_in = total_ff + XTEA_DELTA;
         end
      end
   end

   always_comb begin
      out_hi_in    = out_hi_ff;
      out_lo_in    = out_lo_ff;
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         out_hi_in    = hi_ff;
         out_lo_in    = lo_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hi_ff        <= '0;
         lo_ff        <= '0;
         phase_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff  <= total_in;
      out_hi_ff <= out_hi_in;
      out_lo_ff <= out_lo_in;
   end

   // CSR file
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= KEY0_RESET;
         key_ff[1] <= KEY1_RESET;
         key_ff[2] <= KEY2_RESET;
         key_ff[3] <= KEY3_RESET;
         rounds_ff <= ROUNDS_RESET;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            REG_KEY0:   key_ff[0] <= csr.data;
            REG_KEY1:   key_ff[1] <= csr.data;
            REG_KEY2:   key_ff[2] <= csr.data;
            REG_KEY3:   key_ff[3] <= csr.data;
            REG_ROUNDS: rounds_ff <= csr.data[ROUND_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.cipher_high = out_hi_ff;
   assign rsp.cipher_low  = out_lo_ff;

   `XCBC_ASSERT_NEXT(a_accept_runs, accept, state_ff == ST_RUN, "accept did not start a run")
   `XCBC_ASSERT_SAME(a_idle_phase, state_ff == ST_IDLE, !phase_ff, "odd half-round left in idle")
   `XCBC_ASSERT_NEXT(a_finish_posts, finish, rsp_valid_ff && state_ff == ST_IDLE, "result not posted")
   `XCBC_ASSERT_SAME(a_rsp_rise, $rose(rsp_valid_ff), $past(finish), "response without finish")
   `XCBC_ASSERT_SAME(a_finish_free, finish, !rsp_valid_ff || rsp.ready, "result overwritten")

endmodule
